// ===== rtl/aepool_pkg.sv =====
`timescale 1ns / 1ps
// aepool_pkg: shared types and constants of the aging entry pool
// request and status codes, controller states, stored entry layout; no dependencies

package aepool_pkg;

  localparam int unsigned ReqW     = 2;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned LifeW    = 32;
  localparam int unsigned DeltaW   = 31;
  localparam int unsigned SpeciesW = 32;
  localparam int unsigned FlagW    = 32;
  localparam int unsigned IdW      = 64;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned LiveW    = 7;

  localparam logic [FlagW-1:0] DeadMaskReset = 32'h0000_0001;
  localparam logic [IdW-1:0]   IdReset       = 64'd1;

  typedef enum logic [ReqW-1:0] {
    REQ_SPAWN   = 2'd0,
    REQ_MARK    = 2'd1,
    REQ_AGE     = 2'd2,
    REQ_COMPACT = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_NO_ID = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_AGE,
    ST_COUNT,
    ST_MOVE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [LifeW-1:0]    life;
    logic [SpeciesW-1:0] species;
    logic [FlagW-1:0]    flags;
    logic [IdW-1:0]      id;
  } entry_t;

endpackage

// ===== rtl/aging_entry_pool_with_compaction_core.sv =====
`timescale 1ns / 1ps
// aging entry pool with timeout aging and order-keeping compaction
// depends on aepool_pkg; entries live in one synchronous memory, one entry per word
//
// spawn result goes through ST_FINISH; mark reads the entry, writes it in ST_MARK, then ST_FINISH
// age tick: one memory entry per cycle, then the result from ST_FINISH
// compact: a counting sweep then a move sweep, then the closing result; each move waits
//   for a free output slot on the output side; the read port sets pace
// one request at a time: a new request is taken only once the previous one has finished
// reset clears control, entry count (0), next id (1), dead mask (1); memory is not cleared

module aging_entry_pool_with_compaction_core #(
  parameter int unsigned POOL_DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [aepool_pkg::FlagW-1:0]           cfg_wdata_i,
  // request channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [aepool_pkg::ReqW-1:0]            req_type_i,
  input  logic [aepool_pkg::IndexW-1:0]          entry_index_i,
  input  logic signed [aepool_pkg::LifeW-1:0]    life_time_i,
  input  logic [aepool_pkg::DeltaW-1:0]          delta_time_i,
  input  logic [aepool_pkg::SpeciesW-1:0]        species_in_i,
  input  logic [aepool_pkg::FlagW-1:0]           flags_in_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [aepool_pkg::StatusW-1:0]         status_o,
  output logic [aepool_pkg::IndexW-1:0]          new_index_o,
  output logic [aepool_pkg::IdW-1:0]             new_id_o,
  output logic                                   move_valid_o,
  output logic [aepool_pkg::IndexW-1:0]          move_from_o,
  output logic [aepool_pkg::IndexW-1:0]          move_to_o,
  output logic [aepool_pkg::LiveW-1:0]           live_count_o,
  output logic                                   last_o
);

  import aepool_pkg::*;

  localparam int unsigned IdxW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(POOL_DEPTH + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(POOL_DEPTH);

  // control and bookkeeping registers
  state_e             state_q, state_d;
  logic [FlagW-1:0]   dead_mask_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [IdW-1:0]     next_id_q, next_id_d;
  logic [CntW-1:0]    limit_q, limit_d;     // entries to sweep in this request
  logic [CntW-1:0]    surv_q, surv_d;       // survivors seen in the counting sweep
  logic [IdxW-1:0]    scan_q, scan_d;       // entry whose data sits in rd_q
  logic [IdxW-1:0]    wr_ptr_q, wr_ptr_d;   // compaction destination
  logic [IndexW-1:0]  mark_idx_q, mark_idx_d;
  logic [DeltaW-1:0]  delta_q, delta_d;
  status_e            res_status_q, res_status_d;
  logic [IndexW-1:0]  res_index_q, res_index_d;
  logic [IdW-1:0]     res_id_q, res_id_d;

  // entry memory, one write and one registered read per cycle
  entry_t             mem_q [POOL_DEPTH];
  entry_t             rd_q;
  logic               mem_we, mem_re;
  logic [IdxW-1:0]    mem_waddr, mem_raddr;
  entry_t             mem_wdata;

  // output register
  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [IndexW-1:0]  out_index_q;
  logic [IdW-1:0]     out_id_q;
  logic               out_move_q;
  logic [IndexW-1:0]  out_from_q;
  logic [IndexW-1:0]  out_to_q;
  logic [LiveW-1:0]   out_live_q;
  logic               out_last_q;

  logic               out_load;
  logic [StatusW-1:0] out_status_d;
  logic [IndexW-1:0]  out_index_d;
  logic [IdW-1:0]     out_id_d;
  logic               out_move_d;
  logic [IndexW-1:0]  out_from_d;
  logic [IndexW-1:0]  out_to_d;
  logic               out_last_d;

  logic               can_emit;
  logic               entry_live;
  logic               scan_last;
  logic               need_move;
  logic [LifeW-1:0]   aged_life;
  logic [CntW-1:0]    surv_inc;

  // output slot free now or freed by the current handshake
  assign can_emit   = !out_valid_q || out_ready_i;
  assign entry_live = (rd_q.flags & dead_mask_q) == '0;
  assign scan_last  = CntW'(scan_q) == (limit_q - CntW'(1));
  assign need_move  = entry_live && (wr_ptr_q != scan_q);
  assign aged_life  = rd_q.life - LifeW'(delta_q);
  assign surv_inc   = surv_q + CntW'(entry_live);
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    next_id_d    = next_id_q;
    limit_d      = limit_q;
    surv_d       = surv_q;
    scan_d       = scan_q;
    wr_ptr_d     = wr_ptr_q;
    mark_idx_d   = mark_idx_q;
    delta_d      = delta_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_id_d     = res_id_q;

    mem_we       = 1'b0;
    mem_waddr    = wr_ptr_q;
    mem_wdata    = rd_q;
    mem_re       = 1'b0;
    mem_raddr    = scan_q + IdxW'(1);

    out_load     = 1'b0;
    out_status_d = STATUS_OK;
    out_index_d  = '0;
    out_id_d     = '0;
    out_move_d   = 1'b0;
    out_from_d   = '0;
    out_to_d     = '0;
    out_last_d   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_status_d = STATUS_OK;
          res_index_d  = '0;
          res_id_d     = '0;
          limit_d      = count_q;
          surv_d       = '0;
          scan_d       = '0;
          wr_ptr_d     = '0;
          delta_d      = delta_time_i;
          case (req_e'(req_type_i))
            REQ_SPAWN: begin
              state_d = ST_FINISH;
              // id exhaustion is checked before a full pool
              if (next_id_q == '0) begin
                res_status_d = STATUS_NO_ID;
              end else if (count_q == CntMax) begin
                res_status_d = STATUS_FULL;
              end else begin
                mem_we            = 1'b1;
                mem_waddr         = count_q[IdxW-1:0];
                mem_wdata.life    = life_time_i;
                mem_wdata.species = species_in_i;
                mem_wdata.flags   = flags_in_i;
                mem_wdata.id      = next_id_q;
                res_index_d       = IndexW'(count_q);
                res_id_d          = next_id_q;
                count_d           = count_q + CntW'(1);
                next_id_d         = next_id_q + IdW'(1);
              end
            end
            REQ_MARK: begin
              mem_re     = 1'b1;
              mem_raddr  = entry_index_i[IdxW-1:0];
              mark_idx_d = entry_index_i;
              state_d    = ST_MARK;
            end
            REQ_AGE: begin
              if (delta_time_i == '0 || count_q == '0) begin
                state_d = ST_FINISH;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_d   = ST_AGE;
              end
            end
            REQ_COMPACT: begin
              if (count_q == '0) begin
                state_d = ST_FINISH;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_d   = ST_COUNT;
              end
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end

      ST_MARK: begin
        // out-of-range marks are dropped
        if (LiveW'(mark_idx_q) < LiveW'(count_q)) begin
          mem_we          = 1'b1;
          mem_waddr       = mark_idx_q[IdxW-1:0];
          mem_wdata.flags = rd_q.flags | dead_mask_q;
        end
        state_d = ST_FINISH;
      end

      ST_AGE: begin
        // negative lifetime never expires
        if (!rd_q.life[LifeW-1]) begin
          mem_we         = 1'b1;
          mem_waddr      = scan_q;
          mem_wdata.life = aged_life;
          if (aged_life == '0 || aged_life[LifeW-1]) begin
            mem_wdata.flags = rd_q.flags | dead_mask_q;
          end
        end
        if (scan_last) begin
          state_d = ST_FINISH;
        end else begin
          mem_re = 1'b1;
          scan_d = scan_q + IdxW'(1);
        end
      end

      ST_COUNT: begin
        // first sweep only counts survivors so every move carries the final count
        surv_d = surv_inc;
        mem_re = 1'b1;
        if (scan_last) begin
          count_d   = surv_inc;
          mem_raddr = '0;
          scan_d    = '0;
          state_d   = ST_MOVE;
        end else begin
          scan_d = scan_q + IdxW'(1);
        end
      end

      ST_MOVE: begin
        // a move waits for the output slot; rd_q holds while stalled
        if (!need_move || can_emit) begin
          if (need_move) begin
            mem_we     = 1'b1;
            mem_waddr  = wr_ptr_q;
            mem_wdata  = rd_q;
            out_load   = 1'b1;
            out_move_d = 1'b1;
            out_from_d = IndexW'(scan_q);
            out_to_d   = IndexW'(wr_ptr_q);
          end
          if (entry_live) begin
            wr_ptr_d = wr_ptr_q + IdxW'(1);
          end
          if (scan_last) begin
            state_d = ST_FINISH;
          end else begin
            mem_re = 1'b1;
            scan_d = scan_q + IdxW'(1);
          end
        end
      end

      ST_FINISH: begin
        if (can_emit) begin
          out_load     = 1'b1;
          out_status_d = res_status_q;
          out_index_d  = res_index_q;
          out_id_d     = res_id_q;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      dead_mask_q  <= DeadMaskReset;
      count_q      <= '0;
      next_id_q    <= IdReset;
      limit_q      <= '0;
      surv_q       <= '0;
      scan_q       <= '0;
      wr_ptr_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      next_id_q    <= next_id_d;
      limit_q      <= limit_d;
      surv_q       <= surv_d;
      scan_q       <= scan_d;
      wr_ptr_q     <= wr_ptr_d;
      if (cfg_we_i) begin
        dead_mask_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    mark_idx_q   <= mark_idx_d;
    delta_q      <= delta_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_id_q     <= res_id_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_index_q  <= out_index_d;
      out_id_q     <= out_id_d;
      out_move_q   <= out_move_d;
      out_from_q   <= out_from_d;
      out_to_q     <= out_to_d;
      out_live_q   <= LiveW'(count_d);
      out_last_q   <= out_last_d;
    end
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign new_index_o  = out_index_q;
  assign new_id_o     = out_id_q;
  assign move_valid_o = out_move_q;
  assign move_from_o  = out_from_q;
  assign move_to_o    = out_to_q;
  assign live_count_o = out_live_q;
  assign last_o       = out_last_q;

  // pool never holds more than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("entry count beyond pool depth");

  // sweeps never write the entry being read in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re && (mem_waddr == mem_raddr)))
    else $error("memory read and write hit the same entry");

  // compaction destination never runs ahead of the source
  a_move_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE) |-> (CntW'(wr_ptr_q) <= CntW'(scan_q)))
    else $error("compaction destination above source");

  // a move result is never the closing result
  a_move_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_move_q) |-> !out_last_q)
    else $error("move result flagged last");

  // a stalled move does not touch the memory
  a_stall_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE && need_move && !can_emit) |-> (!mem_we && !mem_re))
    else $error("memory access during stalled move");

endmodule

// ===== tb/aging_entry_pool_with_compaction_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of aging_entry_pool_with_compaction_core: a directed table, then
// random request traffic checked result by result against a cycle-free pool predictor
// depends on aepool_pkg and the core rtl only

module aging_entry_pool_with_compaction_core_tb;

  import aepool_pkg::*;

  localparam int Depth       = 64;
  // a full compaction sweep plus margin, waited out before a mask write and at the end
  localparam int DrainCycles = 2 * Depth + 8;
  // cycles with no request and no result taken before the run is declared hung
  localparam int StallLimit  = 2000;

  // one result as the pool reports it
  typedef struct packed {
    status_e             status;
    logic [IndexW-1:0]   new_index;
    logic [IdW-1:0]      new_id;
    logic                move_valid;
    logic [IndexW-1:0]   move_from;
    logic [IndexW-1:0]   move_to;
    logic [LiveW-1:0]    live_count;
    logic                last;
  } pool_resp_t;

  // one line of the directed table: either a mask write or a request,
  // with the single result typed in where it is obvious
  typedef struct packed {
    logic                is_cfg;
    logic [FlagW-1:0]    cfg_val;
    req_e                kind;
    logic [IndexW-1:0]   idx;
    logic [LifeW-1:0]    life;
    logic [DeltaW-1:0]   delta;
    logic [SpeciesW-1:0] species;
    logic [FlagW-1:0]    flags;
    logic                pin;
    status_e             p_status;
    logic [IndexW-1:0]   p_index;
    logic [IdW-1:0]      p_id;
    logic [LiveW-1:0]    p_live;
  } stim_row_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_we_i      = 1'b0;
  logic [FlagW-1:0]           cfg_wdata_i   = '0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_ready_o;
  logic [ReqW-1:0]            req_type_i    = '0;
  logic [IndexW-1:0]          entry_index_i = '0;
  logic signed [LifeW-1:0]    life_time_i   = '0;
  logic [DeltaW-1:0]          delta_time_i  = '0;
  logic [SpeciesW-1:0]        species_in_i  = '0;
  logic [FlagW-1:0]           flags_in_i    = '0;
  logic                       out_valid_o;
  logic                       out_ready_i   = 1'b0;
  logic [StatusW-1:0]         status_o;
  logic [IndexW-1:0]          new_index_o;
  logic [IdW-1:0]             new_id_o;
  logic                       move_valid_o;
  logic [IndexW-1:0]          move_from_o;
  logic [IndexW-1:0]          move_to_o;
  logic [LiveW-1:0]           live_count_o;
  logic                       last_o;

  // predicted pool contents, kept in step with every accepted request
  logic [LifeW-1:0]    pool_life    [Depth];
  logic [SpeciesW-1:0] pool_species [Depth];
  logic [FlagW-1:0]    pool_flags   [Depth];
  logic [IdW-1:0]      pool_id      [Depth];
  int                  pool_count;
  logic [IdW-1:0]      pool_next_id;
  logic [FlagW-1:0]    pool_mask;

  pool_resp_t expected_responses[$];
  stim_row_t  directed_rows[$];

  int  mismatches      = 0;
  int  requests_sent   = 0;
  int  results_checked = 0;
  int  moves_seen      = 0;
  int  full_rejects    = 0;
  int  masks_written   = 0;
  int  stalled_cycles  = 0;
  logic calm_in  = 1'b0;
  logic calm_out = 1'b0;

  aging_entry_pool_with_compaction_core #(
    .POOL_DEPTH(Depth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .entry_index_i(entry_index_i),
    .life_time_i  (life_time_i),
    .delta_time_i (delta_time_i),
    .species_in_i (species_in_i),
    .flags_in_i   (flags_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .new_index_o  (new_index_o),
    .new_id_o     (new_id_o),
    .move_valid_o (move_valid_o),
    .move_from_o  (move_from_o),
    .move_to_o    (move_to_o),
    .live_count_o (live_count_o),
    .last_o       (last_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // idle length: mostly none, some short, a few long; none at all in a calm stretch
  function automatic int pick_gap(input logic calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // queue one predicted result; live count is the pool size after the request
  task automatic push_response(input status_e st, input logic [IndexW-1:0] nidx,
                               input logic [IdW-1:0] nid, input logic mv,
                               input logic [IndexW-1:0] from_idx,
                               input logic [IndexW-1:0] to_idx, input logic is_last);
    pool_resp_t resp;
    resp.status     = st;
    resp.new_index  = nidx;
    resp.new_id     = nid;
    resp.move_valid = mv;
    resp.move_from  = from_idx;
    resp.move_to    = to_idx;
    resp.live_count = LiveW'(pool_count);
    resp.last       = is_last;
    expected_responses = {expected_responses, resp};
  endtask

  // pool behavior for one accepted request: updates the predicted state and
  // queues every result the request gives
  task automatic predict_pool_response(input req_e kind, input logic [IndexW-1:0] idx,
                                       input logic [LifeW-1:0] life,
                                       input logic [DeltaW-1:0] delta,
                                       input logic [SpeciesW-1:0] species,
                                       input logic [FlagW-1:0] flags);
    logic [LifeW-1:0] lt;
    int w;
    int n_moves;
    int from_list[Depth];
    int to_list[Depth];
    case (kind)
      REQ_SPAWN: begin
        // id exhaustion is checked ahead of a full pool
        if (pool_next_id == '0) begin
          push_response(STATUS_NO_ID, '0, '0, 1'b0, '0, '0, 1'b1);
        end else if (pool_count >= Depth) begin
          push_response(STATUS_FULL, '0, '0, 1'b0, '0, '0, 1'b1);
        end else begin
          pool_life[pool_count]    = life;
          pool_species[pool_count] = species;
          pool_flags[pool_count]   = flags;
          pool_id[pool_count]      = pool_next_id;
          pool_count++;
          push_response(STATUS_OK, IndexW'(pool_count - 1), pool_next_id, 1'b0, '0, '0,
                        1'b1);
          pool_next_id = pool_next_id + 1'b1;
        end
      end
      REQ_MARK: begin
        // an index past the held entries is ignored
        if (int'(idx) < pool_count) pool_flags[idx] = pool_flags[idx] | pool_mask;
        push_response(STATUS_OK, '0, '0, 1'b0, '0, '0, 1'b1);
      end
      REQ_AGE: begin
        if (delta != '0) begin
          for (int r = 0; r < pool_count; r++) begin
            lt = pool_life[r];
            // negative lifetime never expires, including one that aged below zero
            if (!lt[LifeW-1]) begin
              lt = lt - {1'b0, delta};
              pool_life[r] = lt;
              if (lt == '0 || lt[LifeW-1]) pool_flags[r] = pool_flags[r] | pool_mask;
            end
          end
        end
        push_response(STATUS_OK, '0, '0, 1'b0, '0, '0, 1'b1);
      end
      default: begin
        // order-keeping squeeze; every result carries the final count
        w = 0;
        n_moves = 0;
        for (int r = 0; r < pool_count; r++) begin
          if ((pool_flags[r] & pool_mask) == '0) begin
            if (w != r) begin
              pool_life[w]       = pool_life[r];
              pool_species[w]    = pool_species[r];
              pool_flags[w]      = pool_flags[r];
              pool_id[w]         = pool_id[r];
              from_list[n_moves] = r;
              to_list[n_moves]   = w;
              n_moves++;
            end
            w++;
          end
        end
        pool_count = w;
        for (int k = 0; k < n_moves; k++) begin
          push_response(STATUS_OK, '0, '0, 1'b1, IndexW'(from_list[k]), IndexW'(to_list[k]),
                        1'b0);
        end
        push_response(STATUS_OK, '0, '0, 1'b0, '0, '0, 1'b1);
      end
    endcase
  endtask

  // present one request at the falling edge and hold it until taken
  task automatic send_request(input req_e kind, input logic [IndexW-1:0] idx,
                              input logic [LifeW-1:0] life, input logic [DeltaW-1:0] delta,
                              input logic [SpeciesW-1:0] species,
                              input logic [FlagW-1:0] flags);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    entry_index_i <= idx;
    life_time_i   <= life;
    delta_time_i  <= delta;
    species_in_i  <= species;
    flags_in_i    <= flags;
    do @(posedge clk_i); while (!in_ready_o);
    predict_pool_response(kind, idx, life, delta, species, flags);
    requests_sent++;
  endtask

  // random idle time on the request side after a taken request
  task automatic pause_requests();
    int gap;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // drop valid, wait for every predicted result, then let the block settle
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mask writes only while the pool is idle
  task automatic write_dead_mask(input logic [FlagW-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    pool_mask = value;
    masks_written++;
  endtask

  task automatic add_cfg(input logic [FlagW-1:0] value);
    stim_row_t row;
    row = '0;
    row.is_cfg  = 1'b1;
    row.cfg_val = value;
    directed_rows = {directed_rows, row};
  endtask

  task automatic add_req(input req_e kind, input logic [IndexW-1:0] idx,
                         input logic [LifeW-1:0] life, input logic [DeltaW-1:0] delta,
                         input logic [SpeciesW-1:0] species, input logic [FlagW-1:0] flags,
                         input logic pin, input status_e st, input logic [IndexW-1:0] nidx,
                         input logic [IdW-1:0] nid, input logic [LiveW-1:0] live);
    stim_row_t row;
    row = '0;
    row.kind     = kind;
    row.idx      = idx;
    row.life     = life;
    row.delta    = delta;
    row.species  = species;
    row.flags    = flags;
    row.pin      = pin;
    row.p_status = st;
    row.p_index  = nidx;
    row.p_id     = nid;
    row.p_live   = live;
    directed_rows = {directed_rows, row};
  endtask

  // one random request: spawn share as given, the rest split over mark, age, compact
  task automatic random_request(input int spawn_pct);
    int roll;
    int rest;
    req_e kind;
    logic [IndexW-1:0] idx;
    logic [LifeW-1:0] life;
    logic [DeltaW-1:0] delta;
    logic [FlagW-1:0] flags;
    roll = $urandom_range(0, 99);
    rest = 100 - spawn_pct;
    if (roll < spawn_pct) kind = REQ_SPAWN;
    else if (roll < spawn_pct + rest * 2 / 5) kind = REQ_MARK;
    else if (roll < spawn_pct + rest * 4 / 5) kind = REQ_AGE;
    else kind = REQ_COMPACT;
    // marks mostly hit held entries, some land out of range
    if (pool_count > 0 && $urandom_range(0, 4) != 0) begin
      idx = IndexW'($urandom_range(0, pool_count - 1));
    end else begin
      idx = IndexW'($urandom_range(0, Depth - 1));
    end
    case ($urandom_range(0, 9))
      0: life = $urandom | 32'h8000_0000;
      1: begin
        case ($urandom_range(0, 3))
          0: life = 32'h0000_0000;
          1: life = 32'h0000_0001;
          2: life = 32'h7fff_ffff;
          default: life = 32'h8000_0000;
        endcase
      end
      default: life = $urandom_range(0, 32'h0008_0000);
    endcase
    case ($urandom_range(0, 9))
      0: delta = '0;
      1: delta = DeltaW'($urandom);
      default: delta = DeltaW'($urandom_range(1, 32'h0004_0000));
    endcase
    // half the spawns start clean so some entries survive every mask
    flags = ($urandom_range(0, 1) != 0) ? $urandom : '0;
    send_request(kind, idx, life, delta, $urandom, flags);
    pause_requests();
  endtask

  task automatic random_stretch(input int n_items, input int spawn_pct, input logic calm);
    calm_in  = calm | ($urandom_range(0, 3) == 0);
    calm_out = calm | ($urandom_range(0, 3) == 0);
    repeat (n_items) random_request(spawn_pct);
  endtask

  // result side: random stalls, driven at the falling edge
  initial begin : result_ready_driver
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        hold = pick_gap(calm_out);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // every taken result is matched against the oldest prediction
  always @(posedge clk_i) begin : result_checker
    pool_resp_t oldest;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_responses.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
      end else begin
        oldest = expected_responses.pop_front();
        check_field("status", 64'(oldest.status), 64'(status_o));
        check_field("new_index", 64'(oldest.new_index), 64'(new_index_o));
        check_field("new_id", oldest.new_id, new_id_o);
        check_field("move_valid", 64'(oldest.move_valid), 64'(move_valid_o));
        check_field("move_from", 64'(oldest.move_from), 64'(move_from_o));
        check_field("move_to", 64'(oldest.move_to), 64'(move_to_o));
        check_field("live_count", 64'(oldest.live_count), 64'(live_count_o));
        check_field("last", 64'(oldest.last), 64'(last_o));
        results_checked++;
        if (move_valid_o) moves_seen++;
        if (status_o == STATUS_FULL) full_rejects++;
      end
    end
  end

  // hang detection: nothing taken on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t  row;
    pool_resp_t pinned;

    pool_count   = 0;
    pool_next_id = IdReset;
    pool_mask    = DeadMaskReset;

    // requests on an empty pool
    add_req(REQ_COMPACT, 6'd0, 32'h0, 31'h0, 32'h0, 32'h0, 1'b1, STATUS_OK, 6'd0, 64'd0, 7'd0);
    add_req(REQ_MARK, 6'd0, 32'h0, 31'h0, 32'h0, 32'h0, 1'b1, STATUS_OK, 6'd0, 64'd0, 7'd0);
    add_req(REQ_AGE, 6'd0, 32'h0, 31'h7fff_ffff, 32'h0, 32'h0, 1'b1, STATUS_OK, 6'd0, 64'd0,
            7'd0);
    // spawns over the lifetime extremes: max, immortal, zero, most negative, one, already dead
    add_req(REQ_SPAWN, 6'd0, 32'h7fff_ffff, 31'h0, 32'h0, 32'h0, 1'b1, STATUS_OK, 6'd0, 64'd1,
            7'd1);
    add_req(REQ_SPAWN, 6'd0, 32'hffff_ffff, 31'h0, 32'hffff_ffff, 32'hffff_fffe, 1'b1,
            STATUS_OK, 6'd1, 64'd2, 7'd2);
    add_req(REQ_SPAWN, 6'd0, 32'h0, 31'h0, 32'ha5a5_a5a5, 32'h0, 1'b1, STATUS_OK, 6'd2, 64'd3,
            7'd3);
    add_req(REQ_SPAWN, 6'd0, 32'h8000_0000, 31'h0, 32'h5a5a_5a5a, 32'h0, 1'b1, STATUS_OK, 6'd3,
            64'd4, 7'd4);
    add_req(REQ_SPAWN, 6'd0, 32'h1, 31'h0, 32'h1, 32'h0, 1'b1, STATUS_OK, 6'd4, 64'd5, 7'd5);
    add_req(REQ_SPAWN, 6'd0, 32'h0001_0000, 31'h0, 32'h2, 32'h1, 1'b1, STATUS_OK, 6'd5, 64'd6,
            7'd6);
    // zero delta leaves everything, then a one-step tick expires the zero and one lifetimes
    add_req(REQ_AGE, 6'd0, 32'h0, 31'h0, 32'h0, 32'h0, 1'b1, STATUS_OK, 6'd0, 64'd0, 7'd6);
    add_req(REQ_AGE, 6'd0, 32'h0, 31'h1, 32'h0, 32'h0, 1'b1, STATUS_OK, 6'd0, 64'd0, 7'd6);
    // mark past the end is ignored, mark on the immortal entry kills it
    add_req(REQ_MARK, 6'd63, 32'h0, 31'h0, 32'h0, 32'h0, 1'b1, STATUS_OK, 6'd0, 64'd0, 7'd6);
    add_req(REQ_MARK, 6'd1, 32'h0, 31'h0, 32'h0, 32'h0, 1'b1, STATUS_OK, 6'd0, 64'd0, 7'd6);
    // largest delta drives the long lifetimes below zero
    add_req(REQ_AGE, 6'd0, 32'h0, 31'h7fff_ffff, 32'h0, 32'h0, 1'b1, STATUS_OK, 6'd0, 64'd0,
            7'd6);
    add_req(REQ_COMPACT, 6'd0, 32'h0, 31'h0, 32'h0, 32'h0, 1'b0, STATUS_OK, 6'd0, 64'd0, 7'd0);
    // zero mask: nothing can die, compaction keeps all
    add_cfg(32'h0000_0000);
    add_req(REQ_SPAWN, 6'd0, 32'h2, 31'h0, 32'h3, 32'hffff_ffff, 1'b0, STATUS_OK, 6'd0, 64'd0,
            7'd0);
    add_req(REQ_MARK, 6'd1, 32'h0, 31'h0, 32'h0, 32'h0, 1'b0, STATUS_OK, 6'd0, 64'd0, 7'd0);
    add_req(REQ_AGE, 6'd0, 32'h0, 31'h5, 32'h0, 32'h0, 1'b0, STATUS_OK, 6'd0, 64'd0, 7'd0);
    add_req(REQ_COMPACT, 6'd0, 32'h0, 31'h0, 32'h0, 32'h0, 1'b0, STATUS_OK, 6'd0, 64'd0, 7'd0);
    // full mask: the lifetime that aged below zero stays immortal, the all-ones flags die
    add_cfg(32'hffff_ffff);
    add_req(REQ_AGE, 6'd0, 32'h0, 31'h1, 32'h0, 32'h0, 1'b0, STATUS_OK, 6'd0, 64'd0, 7'd0);
    add_req(REQ_COMPACT, 6'd0, 32'h0, 31'h0, 32'h0, 32'h0, 1'b0, STATUS_OK, 6'd0, 64'd0, 7'd0);
    add_cfg(32'h0000_0001);

    // reset held, then released once
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        write_dead_mask(row.cfg_val);
      end else begin
        send_request(row.kind, row.idx, row.life, row.delta, row.species, row.flags);
        if (row.pin) begin
          // typed result replaces the predicted one
          void'(expected_responses.pop_back());
          pinned = '0;
          pinned.status     = row.p_status;
          pinned.new_index  = row.p_index;
          pinned.new_id     = row.p_id;
          pinned.live_count = row.p_live;
          pinned.last       = 1'b1;
          expected_responses = {expected_responses, pinned};
        end
        pause_requests();
      end
    end

    // random traffic under a random mask
    write_dead_mask($urandom);
    random_stretch(6, 45, 1'b0);

    // zero mask: fill the pool to the top, then spawns bounce off as full
    write_dead_mask(32'h0000_0000);
    calm_in  = 1'b0;
    calm_out = 1'b0;
    while (pool_count < Depth) random_request(90);
    repeat (3) random_request(100);

    // full mask on a full pool: an immediate compaction with many moves
    write_dead_mask(32'hffff_ffff);
    send_request(REQ_COMPACT, '0, '0, '0, '0, '0);
    pause_requests();
    random_stretch(6, 45, 1'b0);

    write_dead_mask(32'h0000_0001);
    random_stretch(6, 45, 1'b0);

    // back-to-back stretch with no idling on either side
    write_dead_mask($urandom_range(1, 32'hffff_ffff));
    random_stretch(6, 45, 1'b1);

    drain_results();
    if (expected_responses.size() != 0) begin
      $error("%0d predicted results never arrived", expected_responses.size());
      mismatches++;
    end

    $display("covered %0d requests and %0d results, %0d of them compaction moves",
             requests_sent, results_checked, moves_seen);
    $display("%0d spawns refused on a full pool, %0d dead mask settings, %0d mismatches",
             full_rejects, masks_written, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
